// File: rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared constants and types for the ARP address cache cell chain.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned ENTRIES_DEF = 8;

  localparam logic [10:0] ARP_MIN_LEN     = 11'd28;
  localparam logic [15:0] ARP_HW_ETHERNET = 16'h0001;
  localparam logic [15:0] ARP_PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] ARP_OP_REQUEST  = 16'h0001;

  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic CFG_LOCAL_IP  = 1'b0;
  localparam logic CFG_LOCAL_MAC = 1'b1;

  // search token walking down the cell chain
  typedef struct packed {
    logic        vld;
    logic        is_lookup;
    logic        done;
    logic [31:0] ip;
    logic [47:0] mac;
  } tok_t;

  // direct write into a cell
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] mac;
  } wr_t;

endpackage

// File: rtl/arpc_cell.sv
// ----------------------------------------------------------------------------
// arpc_cell
// One cache entry: holds ip, mac and valid, updates itself from the passing
// token and hands the token on to the next cell through a register.
// ----------------------------------------------------------------------------
module arpc_cell
  import arpc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_in,
  input  wr_t  wr_in,
  output tok_t tok_out
);

  logic        valid_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  tok_t        tok_r;

  logic ip_eq;
  logic store_here;
  logic hit_here;
  tok_t tok_nxt;

  assign ip_eq      = (ip_r == tok_in.ip);
  assign store_here = tok_in.vld && !tok_in.is_lookup && !tok_in.done &&
                      (!valid_r || ip_eq);
  assign hit_here   = tok_in.vld && tok_in.is_lookup && !tok_in.done &&
                      valid_r && ip_eq;

  always_comb begin
    tok_nxt = tok_in;
    if (store_here) begin
      tok_nxt.done = 1'b1;
    end
    if (hit_here) begin
      tok_nxt.done = 1'b1;
      tok_nxt.mac  = mac_r;
    end
  end

  always_ff @(posedge clk) begin
    tok_r.is_lookup <= tok_nxt.is_lookup;
    tok_r.done      <= tok_nxt.done;
    tok_r.ip        <= tok_nxt.ip;
    tok_r.mac       <= tok_nxt.mac;
    if (wr_in.en) begin
      ip_r  <= wr_in.ip;
      mac_r <= wr_in.mac;
    end else if (store_here) begin
      ip_r  <= tok_in.ip;
      mac_r <= tok_in.mac;
    end
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
      if (store_here || wr_in.en) begin
        valid_r <= 1'b1;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

// File: rtl/arp_address_cache.sv
// ----------------------------------------------------------------------------
// arp_address_cache
// ARP cache with responder: checks received packets, learns sender
// addresses into a chain of entry cells, answers requests for the local ip
// and resolves lookup queries.
// path: a beat's token walks the cell chain one entry per cycle into the
// pending reg, then moves on to the output reg; drops go straight to the
// pending reg. A new beat is taken only once the last result has left the
// pending reg for the output reg; in_stall is high until then.
// reset: synchronous active-low rst_n clears all entry valid marks at once,
// local_ip resets to 0
// ----------------------------------------------------------------------------
module arp_address_cache
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [10:0] in_packet_length,
  input  logic [15:0] in_hardware_type,
  input  logic [15:0] in_protocol_type,
  input  logic [15:0] in_opcode,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_sender_ip,
  input  logic [31:0] in_target_ip,
  input  logic [31:0] in_query_ip,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_packet_dropped,
  output logic        out_reply_valid,
  output logic [47:0] out_reply_target_mac,
  output logic [31:0] out_reply_target_ip,
  output logic        out_lookup_hit,
  output logic [47:0] out_found_mac
);

  logic [31:0] local_ip_r;

  logic        busy_r, busy_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        reply_r;
  logic [47:0] reply_mac_r;
  logic [31:0] reply_ip_r;

  logic        pend_drop_r, pend_reply_r, pend_hit_r;
  logic [47:0] pend_rmac_r, pend_found_r;
  logic [31:0] pend_rip_r;

  logic        o_drop_r, o_reply_r, o_hit_r;
  logic [47:0] o_rmac_r, o_found_r;
  logic [31:0] o_rip_r;

  logic in_accept;
  logic drop_c;
  logic move_c;
  tok_t tok [ENTRIES+1];
  wr_t  wr0;
  tok_t tok_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
    end else if (cfg_valid && cfg_index == CFG_LOCAL_IP) begin
      local_ip_r <= cfg_data[31:0];
    end
  end

  assign in_stall  = busy_r;
  assign in_accept = in_valid && !busy_r;
  assign drop_c    = (in_action == ACT_PACKET) &&
                     ((in_packet_length < ARP_MIN_LEN) ||
                      (in_hardware_type != ARP_HW_ETHERNET) ||
                      (in_protocol_type != ARP_PROTO_IPV4));

  always_comb begin
    tok[0].vld       = in_accept && !drop_c;
    tok[0].is_lookup = (in_action == ACT_LOOKUP);
    tok[0].done      = 1'b0;
    tok[0].ip        = (in_action == ACT_LOOKUP) ? in_query_ip : in_sender_ip;
    tok[0].mac       = (in_action == ACT_LOOKUP) ? '0 : in_sender_mac;
  end

  assign tok_end = tok[ENTRIES];

  // table full: entry 0 takes the address once the token leaves unclaimed
  always_comb begin
    wr0.en  = tok_end.vld && !tok_end.is_lookup && !tok_end.done;
    wr0.ip  = tok_end.ip;
    wr0.mac = tok_end.mac;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[g]),
      .wr_in   ((g == 0) ? wr0 : wr_t'('0)),
      .tok_out (tok[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      reply_r     <= (in_action == ACT_PACKET) && !drop_c &&
                     (in_opcode == ARP_OP_REQUEST) && (in_target_ip == local_ip_r);
      reply_mac_r <= in_sender_mac;
      reply_ip_r  <= in_sender_ip;
    end
  end

  assign move_c = pend_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    busy_nxt       = busy_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (move_c) begin
      pend_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      busy_nxt       = 1'b0;
    end
    if (in_accept) begin
      busy_nxt = 1'b1;
    end
    if ((in_accept && drop_c) || tok_end.vld) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && drop_c) begin
      pend_drop_r  <= 1'b1;
      pend_reply_r <= 1'b0;
      pend_rmac_r  <= '0;
      pend_rip_r   <= '0;
      pend_hit_r   <= 1'b0;
      pend_found_r <= '0;
    end else if (tok_end.vld) begin
      pend_drop_r  <= 1'b0;
      pend_reply_r <= reply_r;
      pend_rmac_r  <= reply_r ? reply_mac_r : '0;
      pend_rip_r   <= reply_r ? reply_ip_r : '0;
      pend_hit_r   <= tok_end.is_lookup && tok_end.done;
      pend_found_r <= tok_end.is_lookup ? tok_end.mac : '0;
    end
    if (move_c) begin
      o_drop_r  <= pend_drop_r;
      o_reply_r <= pend_reply_r;
      o_rmac_r  <= pend_rmac_r;
      o_rip_r   <= pend_rip_r;
      o_hit_r   <= pend_hit_r;
      o_found_r <= pend_found_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_packet_dropped   = o_drop_r;
  assign out_reply_valid      = o_reply_r;
  assign out_reply_target_mac = o_rmac_r;
  assign out_reply_target_ip  = o_rip_r;
  assign out_lookup_hit       = o_hit_r;
  assign out_found_mac        = o_found_r;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks arp_address_cache against its own model of the address table
// and the request responder. Each accepted beat is predicted at the
// input handshake and every output beat is compared field by field.
// Directed beats cover drops, replies, updates and table overflow. Six
// random phases follow, each with a new local ip/mac, with random gaps on
// the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;
  import arpc_pkg::*;

  localparam int unsigned CACHE_DEPTH = ENTRIES_DEF;
  localparam int unsigned POOL_SIZE = 12;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_BEATS = 255;
  localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;

  typedef struct packed {
    logic        action;
    logic [10:0] plen;
    logic [15:0] htype;
    logic [15:0] ptype;
    logic [15:0] opcode;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [31:0] qip;
  } arp_beat_t;

  typedef struct packed {
    logic        dropped;
    logic        reply;
    logic [47:0] reply_mac;
    logic [31:0] reply_ip;
    logic        hit;
    logic [47:0] found_mac;
  } arp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_LOCAL_IP;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_packet_dropped;
  logic        out_reply_valid;
  logic [47:0] out_reply_target_mac;
  logic [31:0] out_reply_target_ip;
  logic        out_lookup_hit;
  logic [47:0] out_found_mac;

  arp_beat_t   cur_beat = '0;
  arp_beat_t   pending_beats[$];
  arp_result_t expected_results[$];
  arp_result_t want;

  // model of the table and registers
  logic [31:0] cache_ip [CACHE_DEPTH];
  logic [47:0] cache_mac [CACHE_DEPTH];
  logic        cache_valid [CACHE_DEPTH];
  logic [31:0] own_ip = '0;
  logic [47:0] own_mac = '0;

  int unsigned beats_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_wait = 0;
  int unsigned hold_left = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  arp_address_cache i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (cur_beat.action),
    .in_packet_length     (cur_beat.plen),
    .in_hardware_type     (cur_beat.htype),
    .in_protocol_type     (cur_beat.ptype),
    .in_opcode            (cur_beat.opcode),
    .in_sender_mac        (cur_beat.smac),
    .in_sender_ip         (cur_beat.sip),
    .in_target_ip         (cur_beat.tip),
    .in_query_ip          (cur_beat.qip),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_packet_dropped   (out_packet_dropped),
    .out_reply_valid      (out_reply_valid),
    .out_reply_target_mac (out_reply_target_mac),
    .out_reply_target_ip  (out_reply_target_ip),
    .out_lookup_hit       (out_lookup_hit),
    .out_found_mac        (out_found_mac)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic arp_result_t arp_predict(arp_beat_t b);
    arp_result_t r;
    int slot;
    bit found;
    r = '0;
    found = 1'b0;
    slot = 0;
    if (b.action == ACT_PACKET) begin
      if (b.plen < ARP_MIN_LEN || b.htype != ARP_HW_ETHERNET ||
          b.ptype != ARP_PROTO_IPV4) begin
        r.dropped = 1'b1;
      end else begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (!found && (!cache_valid[i] || cache_ip[i] == b.sip)) begin
            slot = i;
            found = 1'b1;
          end
        end
        cache_ip[slot] = b.sip;
        cache_mac[slot] = b.smac;
        cache_valid[slot] = 1'b1;
        if (b.opcode == ARP_OP_REQUEST && b.tip == own_ip) begin
          r.reply = 1'b1;
          r.reply_mac = b.smac;
          r.reply_ip = b.sip;
        end
      end
    end else begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (!found && cache_valid[i] && cache_ip[i] == b.qip) begin
          r.hit = 1'b1;
          r.found_mac = cache_mac[i];
          found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic arp_beat_t arp_packet(logic [10:0] len, logic [15:0] htype,
                                           logic [15:0] ptype, logic [15:0] op,
                                           logic [47:0] smac, logic [31:0] sip,
                                           logic [31:0] tip);
    arp_beat_t b;
    b.action = ACT_PACKET;
    b.plen = len;
    b.htype = htype;
    b.ptype = ptype;
    b.opcode = op;
    b.smac = smac;
    b.sip = sip;
    b.tip = tip;
    b.qip = $urandom;
    return b;
  endfunction

  // packet fields are don't-care on a lookup, so fill them with noise
  function automatic arp_beat_t arp_query(logic [31:0] qip);
    arp_beat_t b;
    b.action = ACT_LOOKUP;
    b.plen = 11'($urandom);
    b.htype = 16'($urandom);
    b.ptype = 16'($urandom);
    b.opcode = 16'($urandom);
    b.smac = 48'({$urandom, $urandom});
    b.sip = $urandom;
    b.tip = $urandom;
    b.qip = qip;
    return b;
  endfunction

  task automatic queue_beat(arp_beat_t b);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] exp_val);
    if (mismatch_count < 100)
      $display("mismatch on %s: got %h, expected %h", what, got, exp_val);
    mismatch_count++;
  endtask

  // call at a rising edge
  task automatic write_register(logic idx, logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LOCAL_IP) begin
      own_ip = data[31:0];
    end else begin
      own_mac = data;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (results_seen != beats_queued);
  endtask

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(arp_predict(cur_beat));
      if (!in_valid || !in_stall) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          cur_beat <= pending_beats.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_wait <= send_burst ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_packet_dropped !== want.dropped)
            report_mismatch("packet_dropped", 48'(out_packet_dropped), 48'(want.dropped));
          if (out_reply_valid !== want.reply)
            report_mismatch("reply_valid", 48'(out_reply_valid), 48'(want.reply));
          if (out_reply_target_mac !== want.reply_mac)
            report_mismatch("reply_target_mac", out_reply_target_mac, want.reply_mac);
          if (out_reply_target_ip !== want.reply_ip)
            report_mismatch("reply_target_ip", 48'(out_reply_target_ip),
                            48'(want.reply_ip));
          if (out_lookup_hit !== want.hit)
            report_mismatch("lookup_hit", 48'(out_lookup_hit), 48'(want.hit));
          if (out_found_mac !== want.found_mac)
            report_mismatch("found_mac", out_found_mac, want.found_mac);
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        hold_left = recv_burst ? 0 : $urandom_range(0, 5);
      end else if (out_valid && hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  initial begin
    logic [31:0] ip_pool [POOL_SIZE];
    logic [31:0] pick_ip;
    logic [31:0] tip;
    logic [47:0] smac;
    logic [15:0] op;
    arp_beat_t   b;
    int unsigned sel;

    for (int i = 0; i < CACHE_DEPTH; i++) begin
      cache_ip[i] = '0;
      cache_mac[i] = '0;
      cache_valid[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_register(CFG_LOCAL_IP, 48'h0000_0a00_0001);
    write_register(CFG_LOCAL_MAC, 48'h0200_0000_0001);

    // empty table, then drops on each check
    queue_beat(arp_query(32'hc0a8_0001));
    queue_beat(arp_packet(11'd27, ARP_HW_ETHERNET, ARP_PROTO_IPV4, ARP_OP_REQUEST,
                          48'h1111_2222_3333, 32'hc0a8_0001, own_ip));
    queue_beat(arp_packet(11'd0, ARP_HW_ETHERNET, ARP_PROTO_IPV4, ARP_OP_REQUEST,
                          48'h1111_2222_3333, 32'hc0a8_0001, own_ip));
    queue_beat(arp_packet(11'd28, 16'h0000, ARP_PROTO_IPV4, ARP_OP_REQUEST,
                          48'h1111_2222_3333, 32'hc0a8_0001, own_ip));
    queue_beat(arp_packet(11'd28, 16'hffff, ARP_PROTO_IPV4, ARP_OP_REQUEST,
                          48'h1111_2222_3333, 32'hc0a8_0001, own_ip));
    queue_beat(arp_packet(11'd28, ARP_HW_ETHERNET, ETHERTYPE_ARP, ARP_OP_REQUEST,
                          48'h1111_2222_3333, 32'hc0a8_0001, own_ip));
    // learning and replies
    queue_beat(arp_packet(11'd28, ARP_HW_ETHERNET, ARP_PROTO_IPV4, ARP_OP_REQUEST,
                          48'h1111_2222_3333, 32'hc0a8_0001, own_ip));
    queue_beat(arp_packet(11'd2047, ARP_HW_ETHERNET, ARP_PROTO_IPV4, ARP_OP_REPLY,
                          48'h4444_5555_6666, 32'hc0a8_0002, own_ip));
    queue_beat(arp_packet(11'd100, ARP_HW_ETHERNET, ARP_PROTO_IPV4, ARP_OP_REQUEST,
                          48'h7777_8888_9999, 32'hc0a8_0003, 32'h0a00_0002));
    queue_beat(arp_packet(11'd64, ARP_HW_ETHERNET, ARP_PROTO_IPV4, 16'hffff,
                          48'hffff_ffff_ffff, 32'hffff_ffff, own_ip));
    queue_beat(arp_packet(11'd64, ARP_HW_ETHERNET, ARP_PROTO_IPV4, 16'h0000,
                          48'h0000_0000_0000, 32'h0000_0000, own_ip));
    queue_beat(arp_query(32'hc0a8_0001));
    queue_beat(arp_query(32'hc0a8_0002));
    queue_beat(arp_query(32'h0000_0000));
    queue_beat(arp_query(32'hffff_ffff));
    queue_beat(arp_query(32'hc0a8_00ff));
    // update in place
    queue_beat(arp_packet(11'd60, ARP_HW_ETHERNET, ARP_PROTO_IPV4, ARP_OP_REQUEST,
                          48'haaaa_bbbb_cccc, 32'hc0a8_0001, own_ip));
    queue_beat(arp_query(32'hc0a8_0001));
    // fill the table, then overflow onto entry 0
    for (int i = 0; i < 3; i++) begin
      queue_beat(arp_packet(11'd28, ARP_HW_ETHERNET, ARP_PROTO_IPV4, ARP_OP_REPLY,
                            48'h0101_0101_0100 + 48'(i), 32'h0a0a_0a10 + 32'(i), 32'h0));
    end
    queue_beat(arp_packet(11'd28, ARP_HW_ETHERNET, ARP_PROTO_IPV4, ARP_OP_REPLY,
                          48'hdead_beef_0001, 32'h0a0a_0a20, 32'h0));
    queue_beat(arp_query(32'hc0a8_0001));
    queue_beat(arp_query(32'h0a0a_0a20));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      ip_pool[0] = 32'h0000_0000;
      ip_pool[1] = 32'hffff_ffff;
      for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
      case (p)
        0: write_register(CFG_LOCAL_IP, 48'h0);
        1: write_register(CFG_LOCAL_IP, 48'h0000_ffff_ffff);
        default: write_register(CFG_LOCAL_IP, 48'(ip_pool[$urandom_range(0, POOL_SIZE - 1)]));
      endcase
      case (p)
        0: write_register(CFG_LOCAL_MAC, 48'h0);
        1: write_register(CFG_LOCAL_MAC, 48'hffff_ffff_ffff);
        default: write_register(CFG_LOCAL_MAC, 48'({$urandom, $urandom}));
      endcase

      for (int n = 0; n < PHASE_BEATS; n++) begin
        sel = $urandom_range(0, 99);
        pick_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (sel < 35) begin
          queue_beat(arp_query($urandom_range(0, 9) < 8 ? pick_ip : $urandom));
        end else begin
          case ($urandom_range(0, 3))
            0, 1: op = ARP_OP_REQUEST;
            2: op = ARP_OP_REPLY;
            default: op = 16'($urandom);
          endcase
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: tip = own_ip;
            6, 7: tip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
            default: tip = $urandom;
          endcase
          smac = ($urandom_range(0, 9) == 0) ? 48'hffff_ffff_ffff : 48'({$urandom, $urandom});
          b = arp_packet(11'($urandom_range(ARP_MIN_LEN, 2047)), ARP_HW_ETHERNET,
                         ARP_PROTO_IPV4, op, smac,
                         ($urandom_range(0, 9) == 0) ? $urandom : pick_ip, tip);
          if (sel >= 85) begin
            case ($urandom_range(0, 3))
              0: b.plen = 11'($urandom_range(0, ARP_MIN_LEN - 1));
              1: b.htype = 16'($urandom);
              2: b.ptype = 16'($urandom);
              default: begin
                b.plen = 11'($urandom);
                b.htype = 16'($urandom);
                b.ptype = 16'($urandom);
              end
            endcase
          end
          queue_beat(b);
        end
      end
      wait_idle();
    end

    repeat (CACHE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/arpc_pkg.sv
rtl/arpc_cell.sv
rtl/arp_address_cache.sv
tb/sv/testbench.sv
